@@ rtl/core/ttnm_pkg.sv @@
`default_nettype none
package ttnm_pkg;

   // request codes
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_APPLY_CALO   = 3'd0;
   localparam logic [2:0] REG_REVERSE      = 3'd1;
   localparam logic [2:0] REG_TRACK_FLOOR  = 3'd2;
   localparam logic [2:0] REG_ETA_LIMIT    = 3'd3;
   localparam logic [2:0] REG_TOWER_FLOOR  = 3'd4;
   localparam logic [2:0] REG_CONE_SQ      = 3'd5;
   localparam logic [2:0] REG_RATIO_CUT    = 3'd6;

   localparam int ADDR_W = 5;

   localparam logic signed [14:0] PHI_PI     = 15'sd3217;
   localparam logic signed [14:0] PHI_TWO_PI = 15'sd6434;
   localparam logic [26:0]        DIST_MAX   = 27'd134217727;

   typedef struct packed {
      logic [15:0]        pt;
      logic signed [13:0] eta;
      logic signed [12:0] phi;
   } tower_type;

   typedef struct packed {
      logic [15:0] tower_pt_floor;
      logic [12:0] abs_eta_limit;
   } filt_cfg_type;

   typedef struct packed {
      logic        valid;
      logic        elig;
      logic [15:0] pt;
      logic [26:0] dsq;
   } dist_out_type;

endpackage
`default_nettype wire

@@ rtl/core/ttnm_dist.sv @@
`default_nettype none
module ttnm_dist
   import ttnm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire tower_type           tower,
   input  wire logic signed [13:0]  track_eta,
   input  wire logic signed [12:0]  track_phi,
   input  wire filt_cfg_type        cfg,
   output dist_out_type             dout
);

   logic               v1_ff, v2_ff, v3_ff;
   logic               elig1_ff, elig2_ff, elig3_ff;
   logic [15:0]        pt1_ff, pt2_ff, pt3_ff;
   logic signed [14:0] de1_ff, dp1_ff;
   logic [29:0]        desq2_ff, dpsq2_ff;
   logic [26:0]        dist3_ff;

   logic [13:0]        abs_eta;
   logic               elig_in;
   logic signed [14:0] de_in, dp_raw, dp_in;
   logic signed [29:0] desq_s, dpsq_s;
   logic [30:0]        sum;

   // stage 1: differences, phi wrap, eligibility
   always_comb begin
      abs_eta = tower.eta[13] ? 14'(-tower.eta) : tower.eta;
      elig_in = (tower.pt >= cfg.tower_pt_floor) && (abs_eta <= {1'b0, cfg.abs_eta_limit});
      de_in   = 15'(tower.eta) - 15'(track_eta);
      dp_raw  = 15'(tower.phi) - 15'(track_phi);
      if (dp_raw > PHI_PI) begin
         dp_in = dp_raw - PHI_TWO_PI;
      end else if (dp_raw < -PHI_PI) begin
         dp_in = dp_raw + PHI_TWO_PI;
      end else begin
         dp_in = dp_raw;
      end
   end

   // stage 2: squares; stage 3: sum and saturate
   always_comb begin
      desq_s = de1_ff * de1_ff;
      dpsq_s = dp1_ff * dp1_ff;
      sum    = {1'b0, desq2_ff} + {1'b0, dpsq2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      elig1_ff <= elig_in;
      pt1_ff   <= tower.pt;
      de1_ff   <= de_in;
      dp1_ff   <= dp_in;
      elig2_ff <= elig1_ff;
      pt2_ff   <= pt1_ff;
      desq2_ff <= 30'(desq_s);
      dpsq2_ff <= 30'(dpsq_s);
      elig3_ff <= elig2_ff;
      pt3_ff   <= pt2_ff;
      dist3_ff <= (sum > {4'b0, DIST_MAX}) ? DIST_MAX : sum[26:0];
   end

   assign dout.valid = v3_ff;
   assign dout.elig  = elig3_ff;
   assign dout.pt    = pt3_ff;
   assign dout.dsq   = dist3_ff;

endmodule
`default_nettype wire

@@ rtl/core/track_tower_nearest_match_select.sv @@
// Clear and load: the block stays idle, so the next item is taken in the following cycle.
// Query: the scan reads one tower per cycle through the memory's single read port; each
// read passes the read register and the ttnm_dist stages, then the result is registered.
// A new query is taken only once the last result is registered; a held result stalls
// input only once the next query has finished its scan.
// Reset: registers to defaults, tower count to zero; the tower memory is not cleared.
`default_nettype none
module track_tower_nearest_match_select
   import ttnm_pkg::*;
#(
   parameter int MAX_TOWERS = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_type,
   input  wire logic [15:0]         req_item_pt,
   input  wire logic signed [13:0]  req_item_eta,
   input  wire logic signed [12:0]  req_item_phi,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_keep_track,
   output logic                     rsp_found_match,
   output logic [11:0]              rsp_match_index,
   output logic [26:0]              rsp_match_distance_sq,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [ADDR_W-1:0]   paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int AW = (MAX_TOWERS > 1) ? $clog2(MAX_TOWERS) : 1;
   localparam int CW = $clog2(MAX_TOWERS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TOWERS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // configuration
   logic        cfg_apply_ff, cfg_reverse_ff;
   logic [15:0] cfg_trk_floor_ff, cfg_twr_floor_ff;
   logic [12:0] cfg_eta_limit_ff;
   logic [23:0] cfg_cone_ff;
   logic [9:0]  cfg_cut_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_apply_ff     <= 1'b1;
         cfg_reverse_ff   <= 1'b0;
         cfg_trk_floor_ff <= 16'd80;
         cfg_eta_limit_ff <= 13'd2458;
         cfg_twr_floor_ff <= 16'd20;
         cfg_cone_ff      <= 24'd7921;
         cfg_cut_ff       <= 10'd51;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_APPLY_CALO:  cfg_apply_ff     <= pwdata[0];
            REG_REVERSE:     cfg_reverse_ff   <= pwdata[0];
            REG_TRACK_FLOOR: cfg_trk_floor_ff <= pwdata[15:0];
            REG_ETA_LIMIT:   cfg_eta_limit_ff <= pwdata[12:0];
            REG_TOWER_FLOOR: cfg_twr_floor_ff <= pwdata[15:0];
            REG_CONE_SQ:     cfg_cone_ff      <= pwdata[23:0];
            REG_RATIO_CUT:   cfg_cut_ff       <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_APPLY_CALO:  prdata = {31'b0, cfg_apply_ff};
         REG_REVERSE:     prdata = {31'b0, cfg_reverse_ff};
         REG_TRACK_FLOOR: prdata = {16'b0, cfg_trk_floor_ff};
         REG_ETA_LIMIT:   prdata = {19'b0, cfg_eta_limit_ff};
         REG_TOWER_FLOOR: prdata = {16'b0, cfg_twr_floor_ff};
         REG_CONE_SQ:     prdata = {8'b0, cfg_cone_ff};
         REG_RATIO_CUT:   prdata = {22'b0, cfg_cut_ff};
         default:         prdata = 32'b0;
      endcase
   end

   // control
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic [CW-1:0]    arrive_ff, arrive_in;
   logic             accept, is_query, rd_en, wr_en, done_fire;

   // track and running best
   logic [15:0]        trk_pt_ff;
   logic signed [13:0] trk_eta_ff;
   logic signed [12:0] trk_phi_ff;
   logic [25:0]        ratio_thr_ff;
   logic               found_ff;
   logic [26:0]        best_d_ff;
   logic [AW-1:0]      best_idx_ff;
   logic [15:0]        best_pt_ff;
   logic               take_best;

   // memory
   tower_type mem [MAX_TOWERS];
   tower_type rdata_ff, wr_data;
   logic      rvalid_ff;

   filt_cfg_type filt_cfg;
   dist_out_type dout;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_query  = (req_type == REQ_QUERY);
   assign wr_en     = accept && (req_type == REQ_LOAD) && (count_ff < COUNT_MAX);
   assign rd_en     = (state_ff == ST_SCAN) && (scan_ff < count_ff);
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid || rsp_ready);

   assign wr_data.pt  = req_item_pt;
   assign wr_data.eta = req_item_eta;
   assign wr_data.phi = req_item_phi;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[scan_ff[AW-1:0]];
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      arrive_in = arrive_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_CLEAR: count_in = '0;
                  REQ_LOAD:  if (wr_en) count_in = count_ff + 1'b1;
                  REQ_QUERY: begin
                     state_in  = ST_SCAN;
                     scan_in   = '0;
                     arrive_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_en) scan_in = scan_ff + 1'b1;
            if (dout.valid) arrive_in = arrive_ff + 1'b1;
            // all issued towers have been compared
            if (arrive_ff == count_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         scan_ff   <= '0;
         arrive_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         scan_ff   <= scan_in;
         arrive_ff <= arrive_in;
         rvalid_ff <= rd_en;
      end
   end

   assign filt_cfg.tower_pt_floor = cfg_twr_floor_ff;
   assign filt_cfg.abs_eta_limit  = cfg_eta_limit_ff;

   ttnm_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rvalid_ff),
      .tower     (rdata_ff),
      .track_eta (trk_eta_ff),
      .track_phi (trk_phi_ff),
      .cfg       (filt_cfg),
      .dout      (dout)
   );

   // strict less-than keeps the earliest tower on a tie
   assign take_best = dout.valid && dout.elig && (!found_ff || (dout.dsq < best_d_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (accept && is_query) begin
         found_ff <= 1'b0;
      end else if (take_best) begin
         found_ff <= 1'b1;
      end
      if (accept && is_query) begin
         trk_pt_ff    <= req_item_pt;
         trk_eta_ff   <= req_item_eta;
         trk_phi_ff   <= req_item_phi;
         ratio_thr_ff <= {16'b0, cfg_cut_ff} * {10'b0, req_item_pt};
      end
      if (take_best) begin
         best_d_ff   <= dout.dsq;
         best_idx_ff <= arrive_ff[AW-1:0];
         best_pt_ff  <= dout.pt;
      end
   end

   // decision and result register
   logic           keep_raw, keep;
   logic [AW+11:0] idx_wide;

   always_comb begin
      keep_raw = (trk_pt_ff < cfg_trk_floor_ff) ||
                 (found_ff && (best_d_ff < {3'b0, cfg_cone_ff}) &&
                  ({2'b0, best_pt_ff, 8'b0} > ratio_thr_ff));
      keep     = cfg_apply_ff ? (keep_raw ^ cfg_reverse_ff) : 1'b1;
      idx_wide = {12'b0, best_idx_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (done_fire) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
      if (done_fire) begin
         rsp_keep_track        <= keep;
         rsp_found_match       <= found_ff;
         rsp_match_index       <= found_ff ? idx_wide[11:0] : 12'b0;
         rsp_match_distance_sq <= found_ff ? best_d_ff : DIST_MAX;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/ttnm_checker.sv @@
`default_nettype none
module ttnm_checker
   import ttnm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_keep_track,
   input wire logic        rsp_found_match,
   input wire logic [11:0] rsp_match_index,
   input wire logic [26:0] rsp_match_distance_sq
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_keep_track) &&
      $stable(rsp_found_match) && $stable(rsp_match_index) &&
      $stable(rsp_match_distance_sq))
      else $error("result changed while stalled");

   a_no_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found_match |-> rsp_match_index == 12'd0 &&
      rsp_match_distance_sq == DIST_MAX)
      else $error("no-match result carries index or distance");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_QUERY |=> !req_ready)
      else $error("ready stayed high after a query item");

   a_short_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type != REQ_QUERY |=> req_ready)
      else $error("clear or load item blocked input");

   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a finished scan");

endmodule

bind track_tower_nearest_match_select ttnm_checker u_ttnm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .req_type              (req_type),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_keep_track        (rsp_keep_track),
   .rsp_found_match       (rsp_found_match),
   .rsp_match_index       (rsp_match_index),
   .rsp_match_distance_sq (rsp_match_distance_sq)
);
`default_nettype wire
